// ----- rtl/core/fal_pkg.sv -----
// ----------------------------------------------------------------------------
// fal_pkg
// Shared widths, register indexes and controller/datapath interface types
// for the frame allocator.
// ----------------------------------------------------------------------------
package fal_pkg;

    // Field and register widths
    localparam int FRAME_W   = 6;
    localparam int CNT_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 7;

    // Largest capacity the frame number can express
    localparam int CAP_LIMIT = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_MODE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE = 1'd1;

    // Request opcodes
    localparam logic OP_GET   = 1'b0;
    localparam logic OP_TOUCH = 1'b1;

    // Replacement modes
    localparam logic MODE_FIFO = 1'b0;
    localparam logic MODE_LRU  = 1'b1;

    // Commands from controller to datapath (a scan step raises rd_next with scan_adv)
    typedef struct packed {
        logic take;         // latch request, rewind scan pointer to head
        logic grant_new;    // hand out an unused frame, append at tail
        logic rd_head;      // read list head
        logic grant_evict;  // hand out head frame, re-append at tail
        logic rd_ptr;       // read entry at scan pointer
        logic rd_next;      // read entry after scan pointer
        logic scan_adv;     // step scan pointer
        logic rotate;       // move head entry to tail
        logic shift_wr;     // copy next entry down, step scan pointer
        logic put_frame;    // write touched frame at scan pointer
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic mode;         // replacement mode
        logic empty;        // list holds no entries
        logic full;         // list at or above capacity
        logic match;        // read data equals touched frame
        logic at_first;     // scan position is the head
        logic at_last;      // scan position is the tail
        logic at_pen;       // scan position is one before the tail
        logic out_free;     // output register can take a result
    } t_sts;

endpackage

// ----- rtl/core/fal_ram.sv -----
// ----------------------------------------------------------------------------
// fal_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data held while the read enable is low.
// ----------------------------------------------------------------------------
module fal_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/fal_ctrl.sv -----
// ----------------------------------------------------------------------------
// fal_ctrl
// Sequencer for the frame allocator: accepts one request at a time and
// steps the datapath through grant, eviction, scan and shift.
// ----------------------------------------------------------------------------
module fal_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_op,
    input  fal_pkg::t_sts i_sts,
    output fal_pkg::t_cmd o_cmd,
    output logic          o_in_stall
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GET,
        S_EV_OUT,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SH_RD,
        S_SH_WR,
        S_PUT
    } t_state;

    t_state        r_state;
    t_state        n_state;
    fal_pkg::t_cmd w_cmd;
    logic          w_accept;

    assign w_accept = i_in_valid && (r_state == S_IDLE);

    // Decode commands and next state
    always_comb begin
        w_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_cmd.take = 1'b1;
                    if (i_op == fal_pkg::OP_GET) begin
                        n_state = S_GET;
                    end else if (i_sts.mode == fal_pkg::MODE_LRU && !i_sts.empty) begin
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_GET: begin
                if (i_sts.full) begin
                    w_cmd.rd_head = 1'b1;
                    n_state       = S_EV_OUT;
                end else if (i_sts.out_free) begin
                    w_cmd.grant_new = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_EV_OUT: begin
                if (i_sts.out_free) begin
                    w_cmd.grant_evict = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_SCAN_RD: begin
                w_cmd.rd_ptr = 1'b1;
                n_state      = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                priority if (i_sts.match && i_sts.at_last) begin
                    n_state = S_IDLE;
                end else if (i_sts.match && i_sts.at_first) begin
                    w_cmd.rotate = 1'b1;
                    n_state      = S_IDLE;
                end else if (i_sts.match) begin
                    w_cmd.rd_next = 1'b1;
                    n_state       = S_SH_WR;
                end else if (i_sts.at_last) begin
                    n_state = S_IDLE;
                end else begin
                    w_cmd.rd_next  = 1'b1;
                    w_cmd.scan_adv = 1'b1;
                end
            end
            S_SH_RD: begin
                w_cmd.rd_next = 1'b1;
                n_state       = S_SH_WR;
            end
            S_SH_WR: begin
                w_cmd.shift_wr = 1'b1;
                n_state        = i_sts.at_pen ? S_PUT : S_SH_RD;
            end
            S_PUT: begin
                w_cmd.put_frame = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd      = w_cmd;
    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ----- rtl/core/fal_dp.sv -----
// ----------------------------------------------------------------------------
// fal_dp
// Datapath for the frame allocator: configuration registers, the use-order
// list as a circular buffer in RAM, scan pointer and output register.
// ----------------------------------------------------------------------------
module fal_dp #(
    parameter int MAX_FRAMES = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fal_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [fal_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    input  logic [fal_pkg::FRAME_W-1:0]     i_touched_frame,
    input  logic                            i_out_stall,
    input  fal_pkg::t_cmd                   i_cmd,
    output fal_pkg::t_sts                   o_sts,
    output logic                            o_out_valid,
    output logic [fal_pkg::FRAME_W-1:0]     o_granted_frame,
    output logic                            o_evicted
);

    localparam int L_DEPTH = (MAX_FRAMES < fal_pkg::CAP_LIMIT) ? MAX_FRAMES
                                                               : fal_pkg::CAP_LIMIT;
    localparam int L_PTR_W = $clog2(L_DEPTH);
    localparam logic [L_PTR_W-1:0]        L_PTR_LAST = L_PTR_W'(L_DEPTH - 1);
    localparam logic [fal_pkg::CNT_W-1:0] L_CAP_MAX  = fal_pkg::CNT_W'(L_DEPTH);
    localparam logic [fal_pkg::CNT_W-1:0] L_ONE      = fal_pkg::CNT_W'(1);
    localparam logic [fal_pkg::CNT_W-1:0] L_TWO      = fal_pkg::CNT_W'(2);

    function automatic logic [L_PTR_W-1:0] f_inc(input logic [L_PTR_W-1:0] p);
        return (p == L_PTR_LAST) ? '0 : p + L_PTR_W'(1);
    endfunction

    logic                          r_mode;
    logic [fal_pkg::CNT_W-1:0]     r_frames;
    logic [fal_pkg::FRAME_W-1:0]   r_frame;
    logic [L_PTR_W-1:0]            r_head;
    logic [L_PTR_W-1:0]            r_tail;
    logic [L_PTR_W-1:0]            r_ptr;
    logic [fal_pkg::CNT_W-1:0]     r_count;
    logic [fal_pkg::CNT_W-1:0]     r_idx;
    logic                          r_out_valid;
    logic [fal_pkg::FRAME_W-1:0]   r_granted;
    logic                          r_evicted;

    logic [fal_pkg::CNT_W-1:0]     w_cap;
    logic [fal_pkg::CNT_W-1:0]     w_free_top;
    logic                          w_we;
    logic [L_PTR_W-1:0]            w_waddr;
    logic [fal_pkg::FRAME_W-1:0]   w_wdata;
    logic                          w_re;
    logic [L_PTR_W-1:0]            w_raddr;
    logic [fal_pkg::FRAME_W-1:0]   w_rdata;

    // Clamp capacity to the range the list can hold
    always_comb begin
        if (r_frames == '0) begin
            w_cap = L_ONE;
        end else if (r_frames > L_CAP_MAX) begin
            w_cap = L_CAP_MAX;
        end else begin
            w_cap = r_frames;
        end
    end

    // Next unused frame, handed out from the top down
    assign w_free_top = w_cap - r_count - L_ONE;

    // Steer RAM ports
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_tail;
        w_wdata = w_free_top[fal_pkg::FRAME_W-1:0];
        if (i_cmd.grant_new) begin
            w_we = 1'b1;
        end else if (i_cmd.grant_evict) begin
            w_we    = 1'b1;
            w_wdata = w_rdata;
        end else if (i_cmd.rotate) begin
            w_we    = 1'b1;
            w_wdata = r_frame;
        end else if (i_cmd.shift_wr) begin
            w_we    = 1'b1;
            w_waddr = r_ptr;
            w_wdata = w_rdata;
        end else if (i_cmd.put_frame) begin
            w_we    = 1'b1;
            w_waddr = r_ptr;
            w_wdata = r_frame;
        end
    end

    assign w_re    = i_cmd.rd_head || i_cmd.rd_ptr || i_cmd.rd_next;
    assign w_raddr = i_cmd.rd_head ? r_head : (i_cmd.rd_ptr ? r_ptr : f_inc(r_ptr));

    fal_ram #(
        .WIDTH (fal_pkg::FRAME_W),
        .DEPTH (L_DEPTH)
    ) u_list (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Control registers, list pointers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= fal_pkg::MODE_FIFO;
            r_frames    <= fal_pkg::CNT_W'(fal_pkg::CAP_LIMIT);
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Write configuration
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    fal_pkg::CFG_REPLACE_MODE:  r_mode   <= i_cfg_data[0];
                    fal_pkg::CFG_FRAMES_IN_USE: r_frames <= i_cfg_data;
                    default: ;
                endcase
            end
            // Advance list pointers
            if (i_cmd.grant_new) begin
                r_tail  <= f_inc(r_tail);
                r_count <= r_count + L_ONE;
            end else if (i_cmd.grant_evict || i_cmd.rotate) begin
                r_head <= f_inc(r_head);
                r_tail <= f_inc(r_tail);
            end
            // Load or drain the output register
            if (i_cmd.grant_new || i_cmd.grant_evict) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request and result payload, scan position
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_frame <= i_touched_frame;
            r_ptr   <= r_head;
            r_idx   <= '0;
        end else if (i_cmd.scan_adv || i_cmd.shift_wr) begin
            r_ptr <= f_inc(r_ptr);
            r_idx <= r_idx + L_ONE;
        end
        if (i_cmd.grant_new) begin
            r_granted <= w_free_top[fal_pkg::FRAME_W-1:0];
            r_evicted <= 1'b0;
        end else if (i_cmd.grant_evict) begin
            r_granted <= w_rdata;
            r_evicted <= 1'b1;
        end
    end

    // Report status
    assign o_sts.mode     = r_mode;
    assign o_sts.empty    = (r_count == '0);
    assign o_sts.full     = (r_count >= w_cap);
    assign o_sts.match    = (w_rdata == r_frame);
    assign o_sts.at_first = (r_idx == '0);
    assign o_sts.at_last  = (r_idx == r_count - L_ONE);
    assign o_sts.at_pen   = (r_idx == r_count - L_TWO);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid     = r_out_valid;
    assign o_granted_frame = r_granted;
    assign o_evicted       = r_evicted;

endmodule

// ----- rtl/core/frame_allocator_fifo_lru.sv -----
// Get: an unused frame is granted from S_GET; an eviction reads the list head in S_GET
//   (one RAM read) and grants it from S_EV_OUT; the next request waits until the grant.
// LRU touch: S_SCAN_RD starts the scan, S_SCAN_CMP compares entries from the head, then
//   S_SH_RD/S_SH_WR shift entries toward the head and S_PUT writes the tail.
// Reset (synchronous, active low) empties the list and restores FIFO mode and a
//   capacity of 64; the list RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// frame_allocator_fifo_lru
// Physical frame allocator with FIFO or LRU replacement over a use-order list.
// ----------------------------------------------------------------------------
module frame_allocator_fifo_lru #(
    parameter int MAX_FRAMES = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fal_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [fal_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_op,
    input  logic [fal_pkg::FRAME_W-1:0]     i_touched_frame,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [fal_pkg::FRAME_W-1:0]     o_granted_frame,
    output logic                            o_evicted
);

    fal_pkg::t_cmd w_cmd;
    fal_pkg::t_sts w_sts;

    fal_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    fal_dp #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_touched_frame (i_touched_frame),
        .i_out_stall     (i_out_stall),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_out_valid     (o_out_valid),
        .o_granted_frame (o_granted_frame),
        .o_evicted       (o_evicted)
    );

endmodule

// ----- rtl/core/fal_checker.sv -----
// ----------------------------------------------------------------------------
// fal_checker
// Port-level checks for the frame allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fal_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input logic                            i_op,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [fal_pkg::FRAME_W-1:0]     o_granted_frame,
    input logic                            o_evicted
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_granted_frame) && $stable(o_evicted))
        else $error("stalled result changed or dropped");

    // An accepted get request always holds off the request that follows it
    a_get_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_op == fal_pkg::OP_GET) |=> o_in_stall)
        else $error("get request did not hold off the next request");

    // A result appears only after the block has been busy with a request
    a_out_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a request in progress");

    // Reset drops any pending result
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind frame_allocator_fifo_lru fal_checker u_fal_checker (.*);
